FILE: hw/rtl/lscf_pkg.sv
`default_nettype none

package lscf_pkg;

   localparam int unsigned FRONT_LEDS_DEF = 16;
   localparam int unsigned REAR_LEDS_DEF  = 16;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam int unsigned PIXEL_W     = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_COLOR_FRONT     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COLOR_REAR      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BRIGHT_ON       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BRIGHT_OFF      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FADE_AMOUNT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SPEED_THRESHOLD = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_START_FORWARD   = 3'd6;

   localparam logic [23:0] COLOR_FRONT_RST     = 24'hFFFFFF;
   localparam logic [23:0] COLOR_REAR_RST      = 24'hFF0000;
   localparam logic [7:0]  BRIGHT_ON_RST       = 8'd255;
   localparam logic [7:0]  BRIGHT_OFF_RST      = 8'd64;
   localparam logic [7:0]  FADE_AMOUNT_RST     = 8'd75;
   localparam logic [22:0] SPEED_THRESHOLD_RST = 23'd300;

   localparam logic [7:0] RAMP_DOWN = 8'd10;
   localparam logic [7:0] RAMP_UP   = 8'd35;

   typedef struct packed {
      logic signed [23:0] speed;
      logic [15:0]        switch_value;
   } req_type;

   typedef struct packed {
      logic       strip;
      logic [5:0] pixel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] level;
      logic       last;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } state_type;

   function automatic logic [7:0] fade_chan(input logic [7:0] cur, input logic [7:0] tgt,
                                            input logic [7:0] amt);
      logic [7:0]  span;
      logic [15:0] prod;
      logic [7:0]  step;
      span = (cur < tgt) ? (tgt - cur) : (cur - tgt);
      prod = {8'd0, span} * {8'd0, amt};
      step = prod[15:8] + {7'd0, (span != 8'd0) && (amt != 8'd0)};
      return (cur < tgt) ? (cur + step) : (cur - step);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/led_strip_color_fader_unit.sv
// first beat: a taken tick enters the sweep state, which issues a ram read;
//    the faded read data is then registered into the output register
// throughput: one pixel per cycle while rsp_ready stays high
// reset: synchronous, control/config regs to defaults, level zero, forward;
//    per-entry valid bits make every pixel read black, no clearing pass
`default_nettype none

module led_strip_color_fader_unit #(
   parameter int unsigned FRONT_LEDS = lscf_pkg::FRONT_LEDS_DEF,
   parameter int unsigned REAR_LEDS  = lscf_pkg::REAR_LEDS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire lscf_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output lscf_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [lscf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [lscf_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int unsigned TOTAL = FRONT_LEDS + REAR_LEDS;
   localparam int unsigned AW    = $clog2(TOTAL);
   localparam int unsigned CW    = $clog2(TOTAL + 1);
   localparam logic [AW:0]   FRONT_A = (AW + 1)'(FRONT_LEDS);
   localparam logic [CW-1:0] LAST_C  = CW'(TOTAL - 1);
   localparam logic [AW-1:0] LAST_A  = AW'(TOTAL - 1);

   // configuration
   logic [23:0] color_front_ff;
   logic [23:0] color_rear_ff;
   logic [7:0]  bright_on_ff;
   logic [7:0]  bright_off_ff;
   logic [7:0]  fade_amount_ff;
   logic [22:0] speed_threshold_ff;
   logic        csr_write;

   // tick state
   logic                dir_ff, dir_in;
   logic [7:0]          level_ff, level_in;
   lscf_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                req_take;
   logic                rd_issue;

   // read in flight and result buffering
   logic                pend_ff, pend_in;
   logic [AW-1:0]       pend_addr_ff, pend_addr_in;
   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   lscf_pkg::rsp_type   out_data_ff, out_data_in;
   lscf_pkg::rsp_type   skid_data_ff, skid_data_in;
   logic [TOTAL-1:0]    valid_ff, valid_in;
   logic                pop;
   logic [1:0]          occ;
   logic [1:0]          occ_after;
   logic                credit_ok;

   // pixel path
   logic [23:0]         ram_rdata;
   logic [23:0]         cur_px;
   logic [23:0]         tgt_px;
   logic [23:0]         new_px;
   logic                strip_rear;
   logic [AW:0]         rel_index;
   lscf_pkg::rsp_type   land;

   // direction and level
   logic signed [24:0]  spd_ext;
   logic signed [24:0]  th_ext;
   logic [7:0]          lvl_tgt;
   logic [8:0]          lvl_down_lim;
   logic [8:0]          lvl_up_sum;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_take  = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_front_ff     <= lscf_pkg::COLOR_FRONT_RST;
         color_rear_ff      <= lscf_pkg::COLOR_REAR_RST;
         bright_on_ff       <= lscf_pkg::BRIGHT_ON_RST;
         bright_off_ff      <= lscf_pkg::BRIGHT_OFF_RST;
         fade_amount_ff     <= lscf_pkg::FADE_AMOUNT_RST;
         speed_threshold_ff <= lscf_pkg::SPEED_THRESHOLD_RST;
      end else if (csr_write) begin
         case (csr_index)
            lscf_pkg::REG_COLOR_FRONT:     color_front_ff     <= csr_data;
            lscf_pkg::REG_COLOR_REAR:      color_rear_ff      <= csr_data;
            lscf_pkg::REG_BRIGHT_ON:       bright_on_ff       <= csr_data[7:0];
            lscf_pkg::REG_BRIGHT_OFF:      bright_off_ff      <= csr_data[7:0];
            lscf_pkg::REG_FADE_AMOUNT:     fade_amount_ff     <= csr_data[7:0];
            lscf_pkg::REG_SPEED_THRESHOLD: speed_threshold_ff <= csr_data[22:0];
            default: ;
         endcase
      end
   end

   // direction latch with dead band
   always_comb begin
      spd_ext = {req_data.speed[23], req_data.speed};
      th_ext  = $signed({2'b00, speed_threshold_ff});
      dir_in  = dir_ff;
      if (req_take) begin
         if (spd_ext > th_ext) begin
            dir_in = 1'b1;
         end else if (spd_ext < -th_ext) begin
            dir_in = 1'b0;
         end
      end else if (csr_write && (csr_index == lscf_pkg::REG_START_FORWARD)) begin
         dir_in = csr_data[0];
      end
   end

   // brightness ramp
   always_comb begin
      lvl_tgt      = (req_data.switch_value == 16'd0) ? bright_off_ff : bright_on_ff;
      lvl_down_lim = {1'b0, lvl_tgt} + {1'b0, lscf_pkg::RAMP_DOWN};
      lvl_up_sum   = {1'b0, level_ff} + {1'b0, lscf_pkg::RAMP_UP};
      level_in     = level_ff;
      if (req_take) begin
         if (level_ff > lvl_tgt) begin
            level_in = ({1'b0, level_ff} >= lvl_down_lim) ? (level_ff - lscf_pkg::RAMP_DOWN)
                                                           : lvl_tgt;
         end else if (level_ff < lvl_tgt) begin
            level_in = (lvl_up_sum <= {1'b0, lvl_tgt}) ? lvl_up_sum[7:0] : lvl_tgt;
         end
      end
   end

   // credit: one in-flight read plus two result slots, at most two held at once
   always_comb begin
      occ       = {1'b0, pend_ff} + {1'b0, out_valid_ff} + {1'b0, skid_valid_ff};
      occ_after = occ - {1'b0, pop};
      credit_ok = occ_after < 2'd2;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lscf_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = lscf_pkg::ST_SWEEP;
            end
         end
         lscf_pkg::ST_SWEEP: begin
            if (rd_issue && (cnt_ff == LAST_C)) begin
               state_in = lscf_pkg::ST_IDLE;
            end
         end
         default: state_in = lscf_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      rd_issue  = 1'b0;
      case (state_ff)
         lscf_pkg::ST_IDLE:  req_ready = 1'b1;
         lscf_pkg::ST_SWEEP: rd_issue  = credit_ok;
         default: ;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (req_take) begin
         cnt_in = '0;
      end else if (rd_issue) begin
         cnt_in = cnt_ff + 1'b1;
      end
      pend_in      = rd_issue;
      pend_addr_in = rd_issue ? cnt_ff[AW-1:0] : pend_addr_ff;
   end

   lscf_ram #(
      .WIDTH (lscf_pkg::PIXEL_W),
      .DEPTH (TOTAL)
   ) u_ram (
      .clock   (clock),
      .wr_en   (pend_ff),
      .wr_addr (pend_addr_ff),
      .wr_data (new_px),
      .rd_en   (rd_issue),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // fade of the pixel coming out of the ram
   always_comb begin
      cur_px     = valid_ff[pend_addr_ff] ? ram_rdata : '0;
      strip_rear = {1'b0, pend_addr_ff} >= FRONT_A;
      tgt_px     = (strip_rear ^ ~dir_ff) ? color_rear_ff : color_front_ff;
      new_px     = {lscf_pkg::fade_chan(cur_px[23:16], tgt_px[23:16], fade_amount_ff),
                    lscf_pkg::fade_chan(cur_px[15:8],  tgt_px[15:8],  fade_amount_ff),
                    lscf_pkg::fade_chan(cur_px[7:0],   tgt_px[7:0],   fade_amount_ff)};
      rel_index  = strip_rear ? ({1'b0, pend_addr_ff} - FRONT_A) : {1'b0, pend_addr_ff};
      land.strip       = strip_rear;
      land.pixel_index = 6'(rel_index);
      land.red         = new_px[23:16];
      land.green       = new_px[15:8];
      land.blue        = new_px[7:0];
      land.level       = level_ff;
      land.last        = pend_addr_ff == LAST_A;
   end

   // result register with skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      valid_in      = valid_ff;
      if (pend_ff) begin
         valid_in[pend_addr_ff] = 1'b1;
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            if (skid_valid_ff) begin
               out_data_in  = skid_data_ff;
               skid_data_in = land;
            end else begin
               out_data_in = land;
            end
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = land;
         end
      end else if (pop) begin
         out_valid_in  = skid_valid_ff;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff        <= 1'b1;
         level_ff      <= '0;
         state_ff      <= lscf_pkg::ST_IDLE;
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         valid_ff      <= '0;
      end else begin
         dir_ff        <= dir_in;
         level_ff      <= level_in;
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_ff       <= pend_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, pend_ff} + {1'b0, out_valid_ff} + {1'b0, skid_valid_ff}) <= 2'd2)
      else $error("result buffering overrun");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a beat while output register is empty");

   a_pend_from_issue: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(rd_issue))
      else $error("ram read landed without an issue");

   a_tick_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == lscf_pkg::ST_SWEEP) && (cnt_ff == '0))
      else $error("tick beat did not start a sweep");

endmodule

`default_nettype wire

FILE: hw/rtl/lscf_ram.sv
`default_nettype none

module lscf_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
